FILE: rtl/cdq_pkg.sv
// cdq_pkg: shared types and constants of the circular deque.
// No dependencies; every other file of the block uses it.
package cdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PAYLOAD_W      = 32;
    localparam int OCC_W          = 5;

    typedef enum logic [1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_BACK   = 2'd2,
        MODE_POP_FRONT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // result of one item, minus the word that comes back from the store
    typedef struct packed {
        status_t            status;
        logic               is_empty;
        logic [OCC_W-1:0]   occupancy;
        logic               pop_ok;
    } s1_info_t;

endpackage

FILE: rtl/cdq_op_if.sv
// cdq_op_if: operation channel (valid/ready plus mode and push word).
// Depends on cdq_pkg for the payload width.
interface cdq_op_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     mode;
    logic [cdq_pkg::PAYLOAD_W-1:0]  push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

FILE: rtl/cdq_result_if.sv
// cdq_result_if: result channel (valid/ready plus popped word and status).
// Depends on cdq_pkg for the payload and occupancy widths.
interface cdq_result_if;
    logic                           valid;
    logic                           ready;
    logic [cdq_pkg::PAYLOAD_W-1:0]  pop_value;
    logic [1:0]                     status;
    logic                           is_empty;
    logic [cdq_pkg::OCC_W-1:0]      occupancy;

    modport source (output valid, output pop_value, output status, output is_empty,
                    output occupancy, input ready);
    modport sink   (input valid, input pop_value, input status, input is_empty,
                    input occupancy, output ready);
endinterface

FILE: rtl/circular_deque_top.sv
// circular_deque_top: double-ended queue in a circular buffer.
// Pipeline: an accepted item passes the first stage (store read), then the output register.
// Throughput: one item per cycle unless stalled; each successful push or pop touches one store entry.
// Reset: async active-low clears head, tail, count and valid flags; the store is not cleared.
// Depends on cdq_pkg, cdq_op_if, cdq_result_if, cdq_ctrl and cdq_mem.
module circular_deque_top #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cdq_op_if.sink        op,
    cdq_result_if.source  result
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // first stage: pointers moved, store access in flight
    logic                  s1_valid;
    s1_info_t              s1_info;
    logic                  s1_advance;

    // store port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [63:0]           rdata_ext;

    // output register, parts the deque from the consumer
    logic                  out_valid_reg, out_valid_next;
    logic [PAYLOAD_W-1:0]  pop_value_reg, pop_value_next;
    status_t               status_reg;
    logic                  is_empty_reg;
    logic [OCC_W-1:0]      occupancy_reg;

    cdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .s1_advance (s1_advance),
        .s1_valid   (s1_valid),
        .s1_info    (s1_info),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr)
    );

    cdq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // the stage moves on when the output register is free or being drained
    assign s1_advance = !out_valid_reg || result.ready;

    // popped word only on a successful pop, zero on pushes and underflow
    assign rdata_ext      = 64'(mem_rdata);
    assign pop_value_next = s1_info.pop_ok ? rdata_ext[PAYLOAD_W-1:0] : '0;

    always_comb
    begin
        if (s1_valid && s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_advance)
        begin
            pop_value_reg <= pop_value_next;
            status_reg    <= s1_info.status;
            is_empty_reg  <= s1_info.is_empty;
            occupancy_reg <= s1_info.occupancy;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.pop_value = pop_value_reg;
    assign result.status    = status_reg;
    assign result.is_empty  = is_empty_reg;
    assign result.occupancy = occupancy_reg;

endmodule

FILE: rtl/cdq_mem.sv
// cdq_mem: entry store, one write port and one registered read port.
// Depends on cdq_pkg for its parameter defaults.
module cdq_mem #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);
    import cdq_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read, so a stalled result keeps it
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cdq_ctrl.sv
// cdq_ctrl: head/tail pointers, count, store access and the first stage.
// Depends on cdq_pkg and cdq_op_if.
module cdq_ctrl #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cdq_op_if.sink                op,
    input  logic                  s1_advance,
    output logic                  s1_valid,
    output cdq_pkg::s1_info_t     s1_info,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [DATA_WIDTH-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [AW-1:0]         mem_raddr
);
    import cdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          s1_valid_reg, s1_valid_next;
    s1_info_t      s1_info_reg, s1_info_next;

    logic          fire;
    logic          full;
    logic          empty;
    mode_t         mode;
    logic [63:0]   word_ext;
    logic [31:0]   count_ext;

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
    endfunction

    assign op.ready = !s1_valid_reg || s1_advance;
    assign fire     = op.valid && op.ready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign mode     = mode_t'(op.mode);
    assign word_ext = 64'(op.push_value);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = tail_reg;
        mem_raddr  = head_reg;
        mem_wdata  = word_ext[DATA_WIDTH-1:0];
        s1_info_next.status = ST_OK;
        s1_info_next.pop_ok = 1'b0;
        unique case (mode)
            MODE_PUSH_BACK:
            begin
                mem_waddr = tail_reg;
                if (full)
                begin
                    s1_info_next.status = ST_FULL;
                end
                else
                begin
                    mem_we     = fire;
                    tail_next  = slot_next(tail_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_PUSH_FRONT:
            begin
                mem_waddr = slot_prev(head_reg);
                if (full)
                begin
                    s1_info_next.status = ST_FULL;
                end
                else
                begin
                    mem_we     = fire;
                    head_next  = slot_prev(head_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_POP_BACK:
            begin
                mem_raddr = slot_prev(tail_reg);
                if (empty)
                begin
                    s1_info_next.status = ST_EMPTY;
                end
                else
                begin
                    mem_re              = fire;
                    s1_info_next.pop_ok = 1'b1;
                    tail_next           = slot_prev(tail_reg);
                    count_next          = count_reg - CW'(1);
                end
            end
            MODE_POP_FRONT:
            begin
                mem_raddr = head_reg;
                if (empty)
                begin
                    s1_info_next.status = ST_EMPTY;
                end
                else
                begin
                    mem_re              = fire;
                    s1_info_next.pop_ok = 1'b1;
                    head_next           = slot_next(head_reg);
                    count_next          = count_reg - CW'(1);
                end
            end
            default:
            begin
                s1_info_next.status = ST_OK;
            end
        endcase
        count_ext              = 32'(count_next);
        s1_info_next.is_empty  = (count_next == '0);
        s1_info_next.occupancy = count_ext[OCC_W-1:0];
    end

    always_comb
    begin
        if (fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (fire)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_info_reg <= s1_info_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_info  = s1_info_reg;

    // count stays in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("deque count above depth");

    // empty and full both mean the pointers meet
    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> (head_reg == tail_reg))
        else $error("pointers apart on empty or full deque");

    // a rejected push leaves the state alone
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && full && (op.mode == MODE_PUSH_BACK || op.mode == MODE_PUSH_FRONT))
        |=> ($stable(count_reg) && $stable(head_reg) && $stable(tail_reg)))
        else $error("push on full deque changed state");

    // no accept while the first stage is stuck
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |-> !op.ready)
        else $error("item accepted into a stalled stage");

endmodule

FILE: verif/cdq_checker.sv
`timescale 1ns / 1ps
// cdq_checker: watches the operation and result channels of the circular deque,
// predicts each result and compares it field by field. Depends on cdq_pkg.
module cdq_checker
    import cdq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    input  logic                 op_ready,
    input  logic [1:0]           op_mode,
    input  logic [PAYLOAD_W-1:0] op_push_value,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  logic [PAYLOAD_W-1:0] res_pop_value,
    input  logic [1:0]           res_status,
    input  logic                 res_is_empty,
    input  logic [OCC_W-1:0]     res_occupancy,
    output int                   fail_count,
    output int                   pending
);

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [PAYLOAD_W-1:0] WORD_MASK = {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - DATA_WIDTH_DEF);

    typedef struct packed {
        logic [PAYLOAD_W-1:0] pop_value;
        status_t              status;
        logic                 is_empty;
        logic [OCC_W-1:0]     occupancy;
    } deque_result_t;

    // shadow copy of the deque
    logic [PAYLOAD_W-1:0] slot_word [DEPTH];
    int                   front_slot;
    int                   back_slot;   // slot after the back entry
    int                   fill;

    deque_result_t        result_queue [$];

    initial fail_count = 0;
    initial pending = 0;

    function automatic deque_result_t apply_op(mode_t m, logic [PAYLOAD_W-1:0] w);
        deque_result_t r;
        r.pop_value = '0;
        r.status    = ST_OK;
        if (m == MODE_PUSH_BACK || m == MODE_PUSH_FRONT) begin
            if (fill >= DEPTH)
                r.status = ST_FULL;
            else if (m == MODE_PUSH_BACK) begin
                slot_word[back_slot] = w & WORD_MASK;
                back_slot = (back_slot + 1) % DEPTH;
                fill++;
            end
            else begin
                front_slot = (front_slot + DEPTH - 1) % DEPTH;
                slot_word[front_slot] = w & WORD_MASK;
                fill++;
            end
        end
        else begin
            if (fill == 0)
                r.status = ST_EMPTY;
            else if (m == MODE_POP_BACK) begin
                back_slot = (back_slot + DEPTH - 1) % DEPTH;
                r.pop_value = slot_word[back_slot];
                fill--;
            end
            else begin
                r.pop_value = slot_word[front_slot];
                front_slot = (front_slot + 1) % DEPTH;
                fill--;
            end
        end
        r.is_empty  = (fill == 0);
        r.occupancy = OCC_W'(fill);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [PAYLOAD_W-1:0] got,
                                   logic [PAYLOAD_W-1:0] want);
        $display("[%0t] mismatch: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        deque_result_t want;
        if (!rst_n) begin
            front_slot = 0;
            back_slot  = 0;
            fill       = 0;
            result_queue.delete();
            pending = 0;
        end
        else begin
            // predict first, so a result that arrives along with its item would still find it
            if (op_valid && op_ready)
                result_queue.push_back(apply_op(mode_t'(op_mode), op_push_value));
            if (res_valid && res_ready) begin
                if (result_queue.size() == 0)
                    report_mismatch("result with no item pending", res_pop_value, '0);
                else begin
                    want = result_queue.pop_front();
                    if (res_pop_value !== want.pop_value)
                        report_mismatch("pop_value", res_pop_value, want.pop_value);
                    if (res_status !== want.status)
                        report_mismatch("status", PAYLOAD_W'(res_status),
                                        PAYLOAD_W'(want.status));
                    if (res_is_empty !== want.is_empty)
                        report_mismatch("is_empty", PAYLOAD_W'(res_is_empty),
                                        PAYLOAD_W'(want.is_empty));
                    if (res_occupancy !== want.occupancy)
                        report_mismatch("occupancy", PAYLOAD_W'(res_occupancy),
                                        PAYLOAD_W'(want.occupancy));
                end
            end
            pending = result_queue.size();
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: stimulus and verdict for circular_deque_top.
// Depends on cdq_pkg, cdq_op_if, cdq_result_if, cdq_checker and the block itself.
module testbench;
    import cdq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1425;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // Channel locals, all known from time zero; the interfaces follow them.
    logic                 op_valid      = 1'b0;
    logic [1:0]           op_mode       = MODE_PUSH_BACK;
    logic [PAYLOAD_W-1:0] op_push_value = '0;
    logic                 res_ready     = 1'b0;

    // When set, neither side idles: back-to-back items and an always-ready sink.
    logic                 no_stall      = 1'b0;

    int                   fail_count;
    int                   pending;

    cdq_op_if     op_ch ();
    cdq_result_if res_ch ();

    assign op_ch.valid      = op_valid;
    assign op_ch.mode       = op_mode;
    assign op_ch.push_value = op_push_value;
    assign res_ch.ready     = res_ready;

    circular_deque_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op_ch),
        .result (res_ch)
    );

    cdq_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (op_ch.valid),
        .op_ready      (op_ch.ready),
        .op_mode       (op_ch.mode),
        .op_push_value (op_ch.push_value),
        .res_valid     (res_ch.valid),
        .res_ready     (res_ch.ready),
        .res_pop_value (res_ch.pop_value),
        .res_status    (res_ch.status),
        .res_is_empty  (res_ch.is_empty),
        .res_occupancy (res_ch.occupancy),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Idle length: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // Data word: corners (zero, all ones, one-hot) mixed into plain random words.
    function automatic logic [PAYLOAD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return PAYLOAD_W'(1) << $urandom_range(0, PAYLOAD_W - 1);
        else
            return $urandom;
    endfunction

    // bias 0 leans to pushes (reaches full), 1 to pops (reaches empty), 2 is even
    function automatic mode_t pick_mode(int bias);
        int push_pct;
        push_pct = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
        else
            return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    // valid gets one assignment per step: either lowered for a gap or held/raised.
    task automatic send_op(mode_t m, logic [PAYLOAD_W-1:0] w);
        int gap;
        gap = no_stall ? 0 : pick_gap();
        if (gap > 0) begin
            op_valid      <= 1'b0;
            op_mode       <= mode_t'($urandom_range(0, 3));
            op_push_value <= $urandom;
            repeat (gap) @(negedge clk);
        end
        op_valid      <= 1'b1;
        op_mode       <= m;
        op_push_value <= w;
        @(posedge clk);
        while (!op_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sink side: ready toggles between short runs high and random stalls.
    int ready_hold = 0;
    always @(negedge clk) begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (no_stall)
            res_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold--;
        else if (res_ready) begin
            res_ready  <= 1'b0;
            ready_hold = pick_gap();
        end
        else begin
            res_ready  <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end
    end

    // Watchdog: far beyond the slowest legal run (about 1450 items, each with
    // the longest gap and stall, plus the fill of the pipe).
    initial begin
        #5_000_000;
        $display("** circular_deque_top: FAILED **");
        $finish;
    end

    initial begin
        int sent;
        int phase_len;
        int bias;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: pops on an empty queue, both push ends with extreme words,
        // pops from both ends, then fill to the brim, push on a full queue and pop again.
        send_op(MODE_POP_BACK, '1);
        send_op(MODE_POP_FRONT, '1);
        send_op(MODE_PUSH_BACK, '0);
        send_op(MODE_PUSH_FRONT, '1);
        send_op(MODE_POP_BACK, '0);
        send_op(MODE_POP_FRONT, '0);
        for (int i = 0; i < DEPTH; i++)
            send_op((i % 2) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                    (i % 3 == 0) ? ~(PAYLOAD_W'(32'h5A5A_0000) | i) : (PAYLOAD_W'(32'hA5A5_0000) | i));
        send_op(MODE_PUSH_BACK, '1);
        send_op(MODE_PUSH_FRONT, '0);
        send_op(MODE_POP_FRONT, '0);
        send_op(MODE_POP_BACK, '0);

        // Random phases; each picks a push/pop bias and whether both sides
        // run without idling, so full, empty and wrap-around recur.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 80);
            bias      = $urandom_range(0, 2);
            no_stall  <= ($urandom_range(0, 4) == 0);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                send_op(pick_mode(bias), pick_word());
                sent++;
            end
        end

        op_valid <= 1'b0;
        no_stall <= 1'b0;

        // drain, then let the pipe settle so a stray result would show up
        wait (pending == 0);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("** circular_deque_top: PASSED **");
        else
            $display("** circular_deque_top: FAILED **");
        $finish;
    end

endmodule
